FILE: rtl/wave_pkg.sv
// Shared types and constants for the windowed angle velocity estimator.
`timescale 1ns / 1ps

package wave_pkg;

  // Q3.12 angle wrap limits
  localparam logic signed [16:0] PI_Q     = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q = 17'sd25736;

  localparam int TPS_W = 30;
  localparam logic [TPS_W-1:0] TPS_RESET = 30'd1000000;

  // |dangle| * ticks_per_second stays below 2**61
  localparam int MAG_W = 61;
  localparam int CNT_W = $clog2(MAG_W);

  typedef struct packed {
    logic [31:0]        timestamp;
    logic signed [15:0] angle_0;
    logic signed [15:0] angle_1;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity_0;
    logic signed [31:0] velocity_1;
    logic               velocity_fresh;
    logic               saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_UPD,
    S_MUL,
    S_DIV,
    S_SAT,
    S_OUT
  } state_t;

endpackage

FILE: rtl/windowed_angle_velocity_estimator.sv
// Windowed finite-difference velocity estimator with phase unwrap, two servos.
// Per servo an item runs S_RD and S_UPD, and when velocities are recomputed also S_MUL,
//   S_DIV (the shared one-bit-per-cycle restoring divider) and S_SAT; then S_OUT.
// One item at a time: in_ready is high only in S_IDLE, and a result beat still
//   waiting in the output register holds the next result, and so the next item, back.
// Reset (rst_n low, synchronous): pointer, fill flag, angles, velocities, tick rate; no ring clear.
`timescale 1ns / 1ps

module windowed_angle_velocity_estimator
  import wave_pkg::*;
#(
  parameter int WINDOW      = 16,
  parameter int SERVO_COUNT = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TPS_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int UW_D   = WINDOW * SERVO_COUNT;
  localparam int UW_AW  = $clog2(UW_D);
  localparam int SV_W   = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  // ring memories
  logic [31:0] tm_mem [WINDOW];
  logic [31:0] uw_mem [UW_D];

  state_t state_r, state_nxt;

  logic [TPS_W-1:0]  tps_r;
  logic [SLOT_W-1:0] slot_r, slot_next, prev_slot, old_idx;
  logic              filled_r;
  logic [SV_W-1:0]   sv_r;
  logic signed [15:0] last_raw_r [SERVO_COUNT];
  logic signed [31:0] held_r     [SERVO_COUNT];

  in_item_t           in_r;
  logic [31:0]        tm_rd_r, uw_prev_rd_r, uw_old_rd_r;
  logic [31:0]        dt_r;
  logic               fresh_r, clip_r;
  logic signed [31:0] dangle_r;
  logic               neg_r;
  logic [31:0]        rem_r;
  logic [MAG_W-1:0]   quo_r;
  logic [CNT_W-1:0]   cnt_r;

  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              accept, out_load, last_sv;
  logic [UW_AW-1:0]  uw_wa, uw_pa, uw_oa;
  logic signed [15:0] raw;
  logic signed [16:0] step_raw, step;
  logic [31:0]        uw_new;
  logic [31:0]        mag_a;
  logic [61:0]        prod;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic signed [31:0] vel;
  logic               vel_clip;
  logic signed [31:0] vel1_out;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign last_sv   = (sv_r == SV_W'(SERVO_COUNT - 1));

  // ring indexes
  assign slot_next = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
  assign prev_slot = (slot_r == '0) ? SLOT_W'(WINDOW - 1) : slot_r - 1'b1;
  assign old_idx   = slot_next;

  assign uw_wa = UW_AW'(slot_r)    * UW_AW'(SERVO_COUNT) + UW_AW'(sv_r);
  assign uw_pa = UW_AW'(prev_slot) * UW_AW'(SERVO_COUNT) + UW_AW'(sv_r);
  assign uw_oa = UW_AW'(old_idx)   * UW_AW'(SERVO_COUNT) + UW_AW'(sv_r);

  // step wrap: one 2*pi correction when the step lies beyond +/- pi
  always_comb begin
    raw      = (sv_r == '0) ? in_r.angle_0 : in_r.angle_1;
    step_raw = 17'(raw) - 17'(last_raw_r[sv_r]);
    if (step_raw > PI_Q) begin
      step = step_raw - TWO_PI_Q;
    end else if (step_raw < -PI_Q) begin
      step = step_raw + TWO_PI_Q;
    end else begin
      step = step_raw;
    end
    uw_new = filled_r ? (uw_prev_rd_r + 32'(step)) : 32'(raw);
  end

  assign mag_a = dangle_r[31] ? 32'(-dangle_r) : 32'(dangle_r);
  assign prod  = mag_a * tps_r;

  assign rem_sh = {rem_r, quo_r[MAG_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, dt_r});

  // quotient magnitude to signed 32 with clipping
  always_comb begin
    if (neg_r) begin
      vel_clip = (|quo_r[MAG_W-1:32]) || (quo_r[31] && (|quo_r[30:0]));
      vel      = vel_clip ? 32'sh80000000 : 32'(~quo_r[31:0] + 32'd1);
    end else begin
      vel_clip = |quo_r[MAG_W-1:31];
      vel      = vel_clip ? 32'sh7fffffff : 32'(quo_r[31:0]);
    end
  end

  always_comb begin
    vel1_out = '0;
    if (SERVO_COUNT > 1) begin
      vel1_out = held_r[SERVO_COUNT-1];
    end
  end

  // memories: registered reads
  always_ff @(posedge clk) begin
    if (accept) begin
      tm_mem[slot_r] <= in_data.timestamp;
    end
    tm_rd_r <= tm_mem[old_idx];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      uw_mem[uw_wa] <= uw_new;
    end
    uw_prev_rd_r <= uw_mem[uw_pa];
    uw_old_rd_r  <= uw_mem[uw_oa];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_RD;
      S_RD:   state_nxt = S_UPD;
      S_UPD: begin
        if (fresh_r) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = last_sv ? S_OUT : S_RD;
        end
      end
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (cnt_r == '0) state_nxt = S_SAT;
      S_SAT:  state_nxt = last_sv ? S_OUT : S_RD;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= TPS_RESET;
      slot_r      <= '0;
      filled_r    <= 1'b0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        last_raw_r[i] <= '0;
        held_r[i]     <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        tps_r <= cfg_data;
      end
      if (accept) begin
        sv_r <= '0;
      end
      if (state_r == S_UPD) begin
        last_raw_r[sv_r] <= raw;
        if (!fresh_r && !last_sv) sv_r <= sv_r + 1'b1;
      end
      if (state_r == S_SAT) begin
        held_r[sv_r] <= vel;
        if (!last_sv) sv_r <= sv_r + 1'b1;
      end
      if (out_load) begin
        slot_r <= slot_next;
        if (slot_next == '0) filled_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_r   <= in_data;
          clip_r <= 1'b0;
        end
      end
      S_RD: begin
        dt_r    <= in_r.timestamp - tm_rd_r;
        fresh_r <= filled_r && (in_r.timestamp != tm_rd_r);
      end
      S_UPD: begin
        dangle_r <= uw_new - uw_old_rd_r;
      end
      S_MUL: begin
        neg_r <= dangle_r[31];
        quo_r <= prod[MAG_W-1:0];
        rem_r <= '0;
        cnt_r <= CNT_W'(MAG_W - 1);
      end
      S_DIV: begin
        rem_r <= rem_ge ? 32'(rem_sh - {1'b0, dt_r}) : rem_sh[31:0];
        quo_r <= {quo_r[MAG_W-2:0], rem_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      S_SAT: begin
        clip_r <= clip_r | vel_clip;
      end
      S_OUT: begin
        if (out_load) begin
          out_data_r.velocity_0     <= held_r[0];
          out_data_r.velocity_1     <= vel1_out;
          out_data_r.velocity_fresh <= fresh_r;
          out_data_r.saturated      <= clip_r;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/wave_checker.sv
// Port-level checks for the windowed angle velocity estimator, bound to the top level.
`timescale 1ns / 1ps

module wave_checker
  import wave_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_sat_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.velocity_fresh &&
      (out_data.velocity_0 == 32'sh7fffffff || out_data.velocity_0 == 32'sh80000000 ||
       out_data.velocity_1 == 32'sh7fffffff || out_data.velocity_1 == 32'sh80000000))
    else $error("saturated flag without a clipped fresh velocity");

endmodule

bind windowed_angle_velocity_estimator wave_checker u_wave_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/velocity_checker.sv
// Checker for the angle velocity estimator: predicts each result and compares it.
`timescale 1ns / 1ps

module velocity_checker
  import wave_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [TPS_W-1:0] cfg_data,
  output int               pending,
  output int               fail_count
);

  localparam int WIN = 16;
  localparam longint VEL_MAX = 64'sd2147483647;
  localparam longint VEL_MIN = -64'sd2147483648;

  logic [31:0]        ts_hist [WIN];
  logic [31:0]        unwrap_hist [WIN][2];
  int                 prev_angle [2];
  logic signed [31:0] hold_vel [2];
  int                 slot;
  logic               ring_full;
  logic [TPS_W-1:0]   tick_rate;

  out_item_t expected_vel[$];
  out_item_t want;
  int        errors = 0;
  int        queued = 0;
  int        seen = 0;

  assign pending    = queued;
  assign fail_count = errors;

  // Advances the estimator state by one sample and returns the result it produces.
  function automatic out_item_t estimate_velocity(input in_item_t smp);
    out_item_t   r;
    int          prv;
    int          old;
    int          raw;
    int          stp;
    logic [31:0] dt;
    logic [31:0] du;
    longint      num;
    longint      quo;
    logic        fresh;
    logic        clip;
    prv = (slot + WIN - 1) % WIN;
    old = (slot + 1) % WIN;
    fresh = 1'b0;
    clip = 1'b0;
    ts_hist[slot] = smp.timestamp;
    for (int s = 0; s < 2; s++) begin
      raw = (s == 0) ? int'(smp.angle_0) : int'(smp.angle_1);
      stp = raw - prev_angle[s];
      if (stp > int'(PI_Q)) stp -= int'(TWO_PI_Q);
      else if (stp < -int'(PI_Q)) stp += int'(TWO_PI_Q);
      // first pass through the ring keeps the raw angle
      if (ring_full) unwrap_hist[slot][s] = unwrap_hist[prv][s] + stp;
      else unwrap_hist[slot][s] = raw;
      prev_angle[s] = raw;
    end
    if (ring_full) begin
      dt = ts_hist[slot] - ts_hist[old];
      if (dt != 32'd0) begin
        fresh = 1'b1;
        for (int s = 0; s < 2; s++) begin
          du = unwrap_hist[slot][s] - unwrap_hist[old][s];
          num = longint'($signed(du)) * longint'({34'd0, tick_rate});
          quo = num / longint'({32'd0, dt});
          if (quo > VEL_MAX) begin
            hold_vel[s] = 32'h7FFF_FFFF;
            clip = 1'b1;
          end else if (quo < VEL_MIN) begin
            hold_vel[s] = 32'h8000_0000;
            clip = 1'b1;
          end else begin
            hold_vel[s] = quo[31:0];
          end
        end
      end
    end
    slot = (slot + 1) % WIN;
    if (slot == 0) ring_full = 1'b1;
    r.velocity_0     = hold_vel[0];
    r.velocity_1     = hold_vel[1];
    r.velocity_fresh = fresh;
    r.saturated      = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_rate  = TPS_RESET;
      slot       = 0;
      ring_full  = 1'b0;
      prev_angle = '{0, 0};
      hold_vel   = '{32'sd0, 32'sd0};
      expected_vel.delete();
    end else begin
      if (cfg_valid && cfg_ready) tick_rate = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_vel.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %0d: v0=%0d v1=%0d",
                                     seen, out_data.velocity_0, out_data.velocity_1);
        end else begin
          want = expected_vel.pop_front();
          if (out_data.velocity_0 !== want.velocity_0 ||
              out_data.velocity_1 !== want.velocity_1 ||
              out_data.velocity_fresh !== want.velocity_fresh ||
              out_data.saturated !== want.saturated) begin
            errors++;
            if (errors <= 10) begin
              $display("result %0d mismatch: expected v0=%0d v1=%0d fresh=%0b sat=%0b",
                       seen, want.velocity_0, want.velocity_1, want.velocity_fresh,
                       want.saturated);
              $display("  got v0=%0d v1=%0d fresh=%0b sat=%0b", out_data.velocity_0,
                       out_data.velocity_1, out_data.velocity_fresh, out_data.saturated);
            end
          end
        end
        seen++;
      end
      if (in_valid && in_ready) expected_vel = {expected_vel, estimate_velocity(in_data)};
    end
    queued = expected_vel.size();
  end

endmodule

FILE: tb/tb_windowed_angle_velocity_estimator.sv
// Testbench top for the windowed angle velocity estimator: stimulus and verdict.
`timescale 1ns / 1ps

module tb_windowed_angle_velocity_estimator;
  import wave_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [TPS_W-1:0] cfg_data;

  int pending;
  int fail_count;
  int cycles = 0;
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;

  windowed_angle_velocity_estimator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  velocity_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side backpressure: a random stall before each beat while idle_out is set.
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      n = idle_out ? $urandom_range(0, 3) : 0;
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic push_sample(input in_item_t smp);
    int gap;
    gap = idle_in ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Fold an angle back into plus or minus pi, Q3.12.
  function automatic int wrap_pi(input int a);
    int v;
    v = a;
    while (v > int'(PI_Q)) v -= int'(TWO_PI_Q);
    while (v < -int'(PI_Q)) v += int'(TWO_PI_Q);
    return v;
  endfunction

  function automatic int rand_step(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  initial begin
    in_item_t    smp;
    logic [31:0] ts;
    int          a0;
    int          a1;
    int          style;
    int          seg;
    int          spd;
    int          left;
    int unsigned rates [8];
    int          pattern [24];

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    pattern = '{32767, -32768, 0, -1, 12868, 0, -12868, 0, 12869, 0, -12869, 100,
                -100, 25736, -25736, 0,
                // after fill: step of exactly pi, past pi both ways, large raw jumps
                12868, 0, 12869, 0, 32767, -32768, -32768, 32767};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extreme angles, wrap boundaries, timestamp crossing zero
    for (int i = 0; i < 24; i++) begin
      smp.timestamp = 32'(i * 5) - 32'd1;
      smp.angle_0   = pattern[i][15:0];
      smp.angle_1   = ~pattern[i][15:0];
      push_sample(smp);
    end
    ts = smp.timestamp;
    a0 = smp.angle_0;
    a1 = smp.angle_1;

    rates = '{1, 32'h3FFF_FFFF, 0, 1000000000, 1000, 0, 1000000, 0};
    rates[5] = $urandom_range(1, 1000000000);
    rates[7] = $urandom_range(1, 100000);

    for (int p = 0; p < 8; p++) begin
      // tick rate changes only with nothing in flight
      in_valid <= 1'b0;
      while (pending != 0) @(negedge clk);
      repeat (4) @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= rates[p][TPS_W-1:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_valid <= 1'b0;
      idle_in  = (p % 4 != 1) && (p % 4 != 3);
      idle_out = (p % 4 != 2) && (p % 4 != 3);

      left = 160;
      while (left > 0) begin
        style = $urandom_range(0, 9);
        seg   = $urandom_range(17, 40);
        spd   = $urandom_range(0, 6000);
        if (style == 6 || style == 7) begin
          case ($urandom_range(0, 2))
            0: ts = 32'd0;
            1: ts = 32'hFFFF_FFFF;
            default: ;
          endcase
        end
        for (int k = 0; k < seg && left > 0; k++) begin
          case (style)
            4, 5: begin
              ts += $urandom_range(1, 3);
              a0 = wrap_pi(a0 + rand_step(int'(PI_Q)));
              a1 = wrap_pi(a1 + rand_step(int'(PI_Q)));
            end
            6, 7: begin
              // frozen clock: elapsed ticks reach zero across the window
              a0 = wrap_pi(a0 + rand_step(spd));
              a1 = wrap_pi(a1 + rand_step(spd));
            end
            8: begin
              ts = $urandom;
              a0 = int'($urandom);
              a1 = int'($urandom);
            end
            9: begin
              // raw walk that wraps at 16 bits, not at pi
              ts += $urandom_range(0, 100000);
              a0 = a0 + rand_step(spd * 5);
              a1 = a1 + rand_step(spd * 5);
            end
            default: begin
              ts += $urandom_range(1, 2000);
              a0 = wrap_pi(a0 + rand_step(spd));
              a1 = wrap_pi(a1 + rand_step(spd));
            end
          endcase
          smp.timestamp = ts;
          smp.angle_0   = a0[15:0];
          smp.angle_1   = a1[15:0];
          push_sample(smp);
          a0 = smp.angle_0;
          a1 = smp.angle_1;
          left--;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
